@@ sv/tnpq_pkg.sv @@
// Shared types and constants for the timed note-off priority queue.
`default_nettype none

package tnpq_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned DELAY_W      = 32;
  localparam int unsigned CHAN_W       = 4;
  localparam int unsigned KEY_W        = 7;
  localparam int unsigned COUNT_W      = 7;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_POP     = 2'd1,
    OP_ADVANCE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_CLAMP = 2'd3
  } status_e;

  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic [CHAN_W-1:0]  channel;
    logic [KEY_W-1:0]   key;
  } entry_t;

  // Broadcast to every cell in the chain
  typedef struct packed {
    logic               add_en;
    logic               pop_en;
    logic               adv_en;
    logic [DELAY_W-1:0] amount;
    entry_t             new_entry;
  } cmd_t;

  // Handed from a cell to its right-hand neighbour
  typedef struct packed {
    logic   gt;
    entry_t entry;
  } link_t;

endpackage

`default_nettype wire

@@ sv/tnpq_if.sv @@
// Valid/ready channel interfaces for the queue's command and result words.
`default_nettype none

interface tnpq_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [tnpq_pkg::DELAY_W-1:0]  amount;
  logic [tnpq_pkg::CHAN_W-1:0]   channel;
  logic [tnpq_pkg::KEY_W-1:0]    note_key;

  modport source (output valid, operation, amount, channel, note_key, input ready);
  modport sink   (input valid, operation, amount, channel, note_key, output ready);
endinterface

interface tnpq_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [tnpq_pkg::DELAY_W-1:0]  popped_delay;
  logic [tnpq_pkg::CHAN_W-1:0]   popped_channel;
  logic [tnpq_pkg::KEY_W-1:0]    popped_key;
  logic [tnpq_pkg::COUNT_W-1:0]  entry_count;
  logic [tnpq_pkg::DELAY_W-1:0]  head_delay;
  logic                          not_empty;

  modport source (output valid, status, popped_delay, popped_channel, popped_key,
                  entry_count, head_delay, not_empty, input ready);
  modport sink   (input valid, status, popped_delay, popped_channel, popped_key,
                  entry_count, head_delay, not_empty, output ready);
endinterface

`default_nettype wire

@@ sv/tnpq_cell.sv @@
// One slot of the sorted chain: holds an entry, inserts, shifts and ages it.
`default_nettype none

module tnpq_cell (
  input  wire logic             clk_i,
  input  wire tnpq_pkg::cmd_t   cmd_i,
  input  wire logic             occ_i,
  input  wire logic             prev_occ_i,
  input  wire tnpq_pkg::link_t  prev_i,
  input  wire tnpq_pkg::entry_t next_entry_i,
  output tnpq_pkg::link_t       link_o,
  output logic                  clamp_o,
  output logic [tnpq_pkg::DELAY_W-1:0] delay_d_o
);

  tnpq_pkg::entry_t entry_q, entry_d;
  logic             gt;
  logic             below;

  assign gt      = occ_i && (entry_q.delay > cmd_i.amount);
  assign below   = entry_q.delay < cmd_i.amount;
  assign clamp_o = occ_i && below;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.add_en) begin
      // keep a smaller or equal entry; otherwise take the neighbour's or the new one
      if (occ_i && !gt) begin
        entry_d = entry_q;
      end else if (prev_i.gt) begin
        entry_d = prev_i.entry;
      end else if (gt || prev_occ_i) begin
        entry_d = cmd_i.new_entry;
      end
    end else if (cmd_i.pop_en) begin
      entry_d = next_entry_i;
    end else if (cmd_i.adv_en) begin
      entry_d.delay = below ? '0 : entry_q.delay - cmd_i.amount;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign link_o.gt    = gt;
  assign link_o.entry = entry_q;
  assign delay_d_o    = entry_d.delay;

endmodule

`default_nettype wire

@@ sv/timed_note_off_priority_queue.sv @@
// Top level: chain of sorted cells, fill count and the registered result word.
//
// Usage
//   in_i  carries one command word: add (amount is the delay, with channel and
//         note_key), pop the entry with the least delay, or advance time by
//         amount. out_o returns one result word for every command: status,
//         the popped entry, the count and the head delay after the command.
//   Every cell updates in the cycle the command is accepted, so one command is
//   taken per cycle while out_o is not stalled, and its result is valid on
//   out_o the following cycle. The head delay in the result is taken from
//   cell 0's next value.
//   Equal delays leave in the order they were added; an advance clamps each
//   delay at zero and reports that in status.
//   A stalled out_o holds its word; in_i takes a new word only while the
//   result register is empty or being emptied in the same cycle.
//   Reset empties the queue at once (the fill count goes to zero, the entry
//   storage is left as it is) and drops any pending result.
`default_nettype none

module timed_note_off_priority_queue #(
  parameter int unsigned CAPACITY = tnpq_pkg::DEF_CAPACITY
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tnpq_in_if.sink     in_i,
  tnpq_out_if.source  out_o
);

  localparam int unsigned CntW      = $clog2(CAPACITY + 1);
  localparam int unsigned CountOutW = tnpq_pkg::COUNT_W;

  tnpq_pkg::cmd_t   cmd;
  tnpq_pkg::link_t  links   [CAPACITY];
  logic [tnpq_pkg::DELAY_W-1:0] delay_d [CAPACITY];
  logic [CAPACITY-1:0] clamp;

  logic [CntW-1:0] count_q, count_d;
  logic            in_fire;
  logic            full, empty;
  logic            is_add, is_pop, is_adv;

  logic                          out_valid_q;
  tnpq_pkg::status_e             status_q, status_d;
  tnpq_pkg::entry_t              popped_q, popped_d;
  logic [CountOutW-1:0]          count_out_q;
  logic [tnpq_pkg::DELAY_W-1:0]  head_q;
  logic                          not_empty_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign full   = count_q == CntW'(CAPACITY);
  assign empty  = count_q == '0;
  assign is_add = in_i.operation == tnpq_pkg::OP_ADD;
  assign is_pop = in_i.operation == tnpq_pkg::OP_POP;
  assign is_adv = in_i.operation == tnpq_pkg::OP_ADVANCE;

  assign cmd.add_en            = in_fire && is_add && !full;
  assign cmd.pop_en            = in_fire && is_pop && !empty;
  assign cmd.adv_en            = in_fire && is_adv;
  assign cmd.amount            = in_i.amount;
  assign cmd.new_entry.delay   = in_i.amount;
  assign cmd.new_entry.channel = in_i.channel;
  assign cmd.new_entry.key     = in_i.note_key;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    tnpq_pkg::link_t  prev;
    tnpq_pkg::entry_t next_entry;
    logic             occ;
    logic             prev_occ;

    assign occ = CntW'(i) < count_q;

    if (i == 0) begin : g_head
      assign prev_occ    = 1'b1;
      assign prev.gt     = 1'b0;
      assign prev.entry  = links[i].entry;
    end else begin : g_body
      assign prev_occ    = CntW'(i - 1) < count_q;
      assign prev        = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = links[i].entry;
    end else begin : g_mid
      assign next_entry = links[i+1].entry;
    end

    tnpq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occ_i        (occ),
      .prev_occ_i   (prev_occ),
      .prev_i       (prev),
      .next_entry_i (next_entry),
      .link_o       (links[i]),
      .clamp_o      (clamp[i]),
      .delay_d_o    (delay_d[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = tnpq_pkg::ST_OK;
    popped_d = '0;
    case (in_i.operation)
      tnpq_pkg::OP_ADD: begin
        if (full) begin
          status_d = tnpq_pkg::ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      tnpq_pkg::OP_POP: begin
        if (empty) begin
          status_d = tnpq_pkg::ST_EMPTY;
        end else begin
          count_d  = count_q - CntW'(1);
          popped_d = links[0].entry;
        end
      end
      tnpq_pkg::OP_ADVANCE: begin
        if (|clamp) begin
          status_d = tnpq_pkg::ST_CLAMP;
        end
      end
      default: begin
        status_d = tnpq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load with the command, hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q    <= status_d;
      popped_q    <= popped_d;
      count_out_q <= CountOutW'(count_d);
      head_q      <= (count_d != '0) ? delay_d[0] : '0;
      not_empty_q <= count_d != '0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = status_q;
  assign out_o.popped_delay   = popped_q.delay;
  assign out_o.popped_channel = popped_q.channel;
  assign out_o.popped_key     = popped_q.key;
  assign out_o.entry_count    = count_out_q;
  assign out_o.head_delay     = head_q;
  assign out_o.not_empty      = not_empty_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_pop && !empty |=>
      out_valid_q && count_q == $past(count_q) - CntW'(1) &&
      status_q == tnpq_pkg::ST_OK)
    else $error("pop on a filled queue did not remove one word");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_add && full |=>
      count_q == $past(count_q) && status_q == tnpq_pkg::ST_FULL)
    else $error("add on a full queue changed the count");

  a_clamp_only_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !is_adv |=> status_q != tnpq_pkg::ST_CLAMP)
    else $error("clamp status without an advance");

endmodule

`default_nettype wire

@@ verif/timed_note_off_priority_queue_tb.sv @@
// Self-checking bench for the timed note-off queue: directed and random commands, scored.
`default_nettype none

module timed_note_off_priority_queue_tb;

  localparam int unsigned CAPACITY = tnpq_pkg::DEF_CAPACITY;
  localparam int unsigned DELAY_W  = tnpq_pkg::DELAY_W;
  localparam int unsigned CHAN_W   = tnpq_pkg::CHAN_W;
  localparam int unsigned KEY_W    = tnpq_pkg::KEY_W;
  localparam int unsigned COUNT_W  = tnpq_pkg::COUNT_W;
  localparam logic [1:0]  OP_IDLE  = 2'd3;   // selector with no meaning
  localparam int unsigned CALM_LO  = 180;
  localparam int unsigned CALM_HI  = 260;
  localparam int unsigned IDLE_PCT = 27;

  typedef struct {
    logic [1:0]         op;
    logic [DELAY_W-1:0] amount;
    logic [CHAN_W-1:0]  channel;
    logic [KEY_W-1:0]   note_key;
    bit                 drain_first;
  } note_cmd_t;

  typedef struct {
    logic [1:0]         status;
    logic [DELAY_W-1:0] popped_delay;
    logic [CHAN_W-1:0]  popped_channel;
    logic [KEY_W-1:0]   popped_key;
    logic [COUNT_W-1:0] entry_count;
    logic [DELAY_W-1:0] head_delay;
    logic               not_empty;
  } note_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tnpq_in_if  in_if ();
  tnpq_out_if out_if ();

  timed_note_off_priority_queue #(.CAPACITY(CAPACITY)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 0;
  end

  note_cmd_t         cmd_backlog[$];
  note_result_t      result_words_due[$];
  tnpq_pkg::entry_t  held_notes[$];
  int unsigned       words_in;
  int unsigned       words_out;
  int unsigned       fail_count;
  int unsigned       n_add, n_pop, n_adv, n_idle;
  int unsigned       n_full, n_empty, n_clamp;

  // Sorted insert keeps ties in arrival order: stop at the first delay not above the new one
  function automatic note_result_t apply_note_cmd(logic [1:0] op, logic [DELAY_W-1:0] amount,
                                                  logic [CHAN_W-1:0] chan,
                                                  logic [KEY_W-1:0] key);
    note_result_t     r;
    tnpq_pkg::entry_t e;
    int               pos;
    r = '{default: '0};
    r.status = tnpq_pkg::ST_OK;
    case (op)
      tnpq_pkg::OP_ADD: begin
        if (held_notes.size() >= CAPACITY) begin
          r.status = tnpq_pkg::ST_FULL;
        end else begin
          e.delay   = amount;
          e.channel = chan;
          e.key     = key;
          pos = held_notes.size();
          while (pos > 0 && held_notes[pos-1].delay > amount) pos--;
          held_notes.insert(pos, e);
        end
      end
      tnpq_pkg::OP_POP: begin
        if (held_notes.size() == 0) begin
          r.status = tnpq_pkg::ST_EMPTY;
        end else begin
          e = held_notes.pop_front();
          r.popped_delay   = e.delay;
          r.popped_channel = e.channel;
          r.popped_key     = e.key;
        end
      end
      tnpq_pkg::OP_ADVANCE: begin
        foreach (held_notes[i]) begin
          if (held_notes[i].delay < amount) begin
            held_notes[i].delay = '0;
            r.status = tnpq_pkg::ST_CLAMP;
          end else begin
            held_notes[i].delay = held_notes[i].delay - amount;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_W'(held_notes.size());
    r.head_delay  = (held_notes.size() > 0) ? held_notes[0].delay : '0;
    r.not_empty   = (held_notes.size() > 0);
    return r;
  endfunction

  task automatic check_field(string name, logic [DELAY_W-1:0] want, logic [DELAY_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic push_cmd(logic [1:0] op, logic [DELAY_W-1:0] amount, logic [CHAN_W-1:0] chan,
                          logic [KEY_W-1:0] key, bit drain_first);
    note_cmd_t c;
    c.op          = op;
    c.amount      = amount;
    c.channel     = chan;
    c.note_key    = key;
    c.drain_first = drain_first;
    cmd_backlog.push_back(c);
  endtask

  // Small delays give plenty of ties; a few full-range values exercise the top bits
  function automatic logic [DELAY_W-1:0] pick_amount(logic [1:0] op);
    int unsigned roll;
    roll = $urandom_range(99);
    if (op == tnpq_pkg::OP_ADVANCE) begin
      if (roll < 60) return $urandom_range(8);
      if (roll < 90) return $urandom_range(500);
      return $urandom;
    end
    if (roll < 50) return $urandom_range(15);
    if (roll < 75) return $urandom_range(1000);
    return $urandom;
  endfunction

  // Weights in percent for add, pop and advance; the remainder is the idle selector
  task automatic push_random(int unsigned count, int unsigned w_add, int unsigned w_pop,
                             int unsigned w_adv);
    int unsigned roll;
    logic [1:0]  op;
    for (int unsigned i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < w_add) op = tnpq_pkg::OP_ADD;
      else if (roll < w_add + w_pop) op = tnpq_pkg::OP_POP;
      else if (roll < w_add + w_pop + w_adv) op = tnpq_pkg::OP_ADVANCE;
      else op = OP_IDLE;
      push_cmd(op, pick_amount(op), CHAN_W'($urandom_range(15)),
               KEY_W'($urandom_range(127)), 1'b0);
    end
  endtask

  // Command side: one word per handshake, fed from the backlog
  always @(posedge clk_i or negedge rst_ni) begin : drive_cmds
    note_cmd_t   c;
    bit          go;
    int unsigned words_sent;
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.operation <= '0;
      in_if.amount    <= '0;
      in_if.channel   <= '0;
      in_if.note_key  <= '0;
      words_sent = 0;
    end else if (!in_if.valid || in_if.ready) begin
      go = (cmd_backlog.size() > 0) &&
           ((words_sent >= CALM_LO && words_sent < CALM_HI) ||
            $urandom_range(99) >= IDLE_PCT);
      // hold a drain-first word back until every result has been taken
      if (go && cmd_backlog[0].drain_first && (in_if.valid || words_in != words_out))
        go = 1'b0;
      if (go) begin
        c = cmd_backlog.pop_front();
        in_if.operation <= c.op;
        in_if.amount    <= c.amount;
        in_if.channel   <= c.channel;
        in_if.note_key  <= c.note_key;
        words_sent++;
      end
      in_if.valid <= go;
    end
  end

  // Result side: predict on each accepted command, score each accepted result
  always @(posedge clk_i or negedge rst_ni) begin : score_results
    note_result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      words_in     <= 0;
      words_out    <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        result_words_due.push_back(apply_note_cmd(in_if.operation, in_if.amount,
                                                  in_if.channel, in_if.note_key));
        words_in <= words_in + 1;
        case (in_if.operation)
          tnpq_pkg::OP_ADD:     n_add++;
          tnpq_pkg::OP_POP:     n_pop++;
          tnpq_pkg::OP_ADVANCE: n_adv++;
          default:              n_idle++;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        words_out <= words_out + 1;
        if (result_words_due.size() == 0) begin
          $error("result word arrived with nothing pending");
          fail_count++;
        end else begin
          want = result_words_due.pop_front();
          check_field("status", want.status, out_if.status);
          check_field("popped_delay", want.popped_delay, out_if.popped_delay);
          check_field("popped_channel", want.popped_channel, out_if.popped_channel);
          check_field("popped_key", want.popped_key, out_if.popped_key);
          check_field("entry_count", want.entry_count, out_if.entry_count);
          check_field("head_delay", want.head_delay, out_if.head_delay);
          check_field("not_empty", want.not_empty, out_if.not_empty);
          case (want.status)
            tnpq_pkg::ST_FULL:  n_full++;
            tnpq_pkg::ST_EMPTY: n_empty++;
            tnpq_pkg::ST_CLAMP: n_clamp++;
            default:            ;
          endcase
        end
      end
      out_if.ready <= (words_out >= CALM_LO && words_out < CALM_HI) ||
                      ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.operation = '0;
    in_if.amount    = '0;
    in_if.channel   = '0;
    in_if.note_key  = '0;
    out_if.ready    = 1'b0;
    fail_count      = 0;

    // Directed: empty-queue cases, field extremes, ties, clamping and exact advance
    push_cmd(tnpq_pkg::OP_POP, '0, '0, '0, 1'b0);
    push_cmd(tnpq_pkg::OP_ADVANCE, 32'd5, '0, '0, 1'b0);
    push_cmd(OP_IDLE, 32'hFFFF_FFFF, 4'hF, 7'h7F, 1'b0);
    push_cmd(tnpq_pkg::OP_ADD, '0, '0, '0, 1'b0);
    push_cmd(tnpq_pkg::OP_ADD, 32'hFFFF_FFFF, 4'hF, 7'h7F, 1'b0);
    push_cmd(tnpq_pkg::OP_ADD, 32'd100, 4'd3, 7'd60, 1'b0);
    push_cmd(tnpq_pkg::OP_ADD, 32'd100, 4'd4, 7'd61, 1'b0);
    push_cmd(tnpq_pkg::OP_ADD, 32'd100, 4'd5, 7'd62, 1'b0);
    push_cmd(OP_IDLE, 32'd7, 4'd9, 7'd33, 1'b0);
    push_cmd(tnpq_pkg::OP_ADVANCE, '0, 4'hF, 7'h7F, 1'b0);
    push_cmd(tnpq_pkg::OP_ADVANCE, 32'd40, '0, '0, 1'b0);
    push_cmd(tnpq_pkg::OP_POP, 32'hFFFF_FFFF, 4'hF, 7'h7F, 1'b0);
    push_cmd(tnpq_pkg::OP_POP, '0, '0, '0, 1'b0);
    push_cmd(tnpq_pkg::OP_ADVANCE, 32'hFFFF_FFFF, '0, '0, 1'b0);
    push_cmd(tnpq_pkg::OP_POP, '0, '0, '0, 1'b0);
    push_cmd(tnpq_pkg::OP_POP, '0, '0, '0, 1'b0);
    push_cmd(tnpq_pkg::OP_POP, '0, '0, '0, 1'b0);
    push_cmd(tnpq_pkg::OP_POP, '0, '0, '0, 1'b0);
    push_cmd(tnpq_pkg::OP_ADD, 32'd50, 4'd1, 7'd10, 1'b1);
    push_cmd(tnpq_pkg::OP_ADVANCE, 32'd50, '0, '0, 1'b0);
    push_cmd(tnpq_pkg::OP_POP, '0, '0, '0, 1'b0);

    // Random: fill past capacity, drain past empty, then a long mixed stretch
    push_random(90, 92, 6, 1);
    push_random(100, 6, 92, 1);
    push_random(120, 40, 35, 20);
    push_cmd(tnpq_pkg::OP_ADVANCE, DELAY_W'($urandom_range(20)),
             CHAN_W'($urandom_range(15)), KEY_W'($urandom_range(127)), 1'b1);
    push_random(120, 42, 33, 20);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample between edges so the driver and scoreboard have settled
    while (cmd_backlog.size() != 0 || in_if.valid || words_in != words_out)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);

    if (result_words_due.size() != 0) begin
      $error("%0d expected result words never arrived", result_words_due.size());
      fail_count++;
    end
    $display("Ran %0d commands: %0d adds, %0d pops, %0d advances, %0d idle selectors.",
             n_add + n_pop + n_adv + n_idle, n_add, n_pop, n_adv, n_idle);
    $display("Saw %0d dropped adds on a full queue, %0d pops on empty, %0d clamped advances.",
             n_full, n_empty, n_clamp);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
